// File: rtl/drf_pkg.sv
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types and constants for the DMA descriptor ring feeder.
// ----------------------------------------------------------------------------
package drf_pkg;

    localparam int RING_SLOTS  = 32;
    localparam int CHUNK_BYTES = 4096;
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);

    localparam int SLOT_W  = 5;
    localparam int FIFO_W  = 19;
    localparam int TAKE_W  = 13;
    localparam int ADDR_W  = 32;
    localparam int PREB_W  = 5;

    localparam logic [SLOT_W-1:0] MAX_IN_FLIGHT = SLOT_W'(RING_SLOTS - 1);
    localparam logic [PREB_W-1:0] PREBUF_RESET  = PREB_W'(8);

    // event codes
    localparam logic [1:0] OP_KICK  = 2'd0;
    localparam logic [1:0] OP_IRQ   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // configuration register indexes
    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_PREBUF = 1'b1;

    typedef enum logic [1:0] {
        KIND_SLOT     = 2'd0,
        KIND_HALT_ACK = 2'd1,
        KIND_START    = 2'd2,
        KIND_SUMMARY  = 2'd3
    } kind_t;

    // result of one pass through the slot arithmetic unit
    typedef struct packed {
        logic [TAKE_W-1:0] take;
        logic [FIFO_W-1:0] rem_next;
        logic [ADDR_W-1:0] addr;
    } slot_calc_t;

endpackage

// File: rtl/drf_slot_unit.sv
// ----------------------------------------------------------------------------
// drf_slot_unit
// Shared slot arithmetic: chunk size taken from the FIFO level, remaining
// level, and slot buffer address.
// ----------------------------------------------------------------------------
module drf_slot_unit (
    input  logic [drf_pkg::FIFO_W-1:0] rem,
    input  logic [drf_pkg::SLOT_W-1:0] slot,
    input  logic [drf_pkg::ADDR_W-1:0] base,
    output drf_pkg::slot_calc_t        calc
);

    logic [drf_pkg::TAKE_W-1:0] take;
    logic [drf_pkg::ADDR_W-1:0] offset;

    always_comb begin
        if (rem > drf_pkg::FIFO_W'(drf_pkg::CHUNK_BYTES)) begin
            take = drf_pkg::TAKE_W'(drf_pkg::CHUNK_BYTES);
        end else begin
            take = rem[drf_pkg::TAKE_W-1:0];
        end
    end

    assign offset        = drf_pkg::ADDR_W'(slot) << drf_pkg::CHUNK_SHIFT;
    assign calc.take     = take;
    assign calc.rem_next = rem - drf_pkg::FIFO_W'(take);
    assign calc.addr     = base + offset;

endmodule

// File: rtl/dma_descriptor_ring_feeder_unit.sv
// ----------------------------------------------------------------------------
// dma_descriptor_ring_feeder_unit
// Keeps a ring of DMA descriptor slots filled from a staging FIFO and starts
// the playback engine.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one event per transfer (kick, slot-completed, flush) with the
//   FIFO byte level and the engine halted bit. s_ready is high only while the
//   sequencer is idle; one event is worked on at a time.
//   m_* channel: per event, an optional halt acknowledge, one descriptor per
//   filled slot, an optional engine start, then a summary with m_last set.
//   cfg_*: register writes (0 chunk base address, 1 prebuffer slots), to be
//   made while no event is in progress; the block itself does not enforce it.
// Timing: the sequencer steps one result per cycle through the shared slot
//   arithmetic unit while the output register is free, and returns to idle
//   once an event's summary is loaded into the output register, so the next
//   event can be accepted. The summary is presented in the same cycle that
//   s_ready returns.
// Stall: the output register holds a result until it is taken; the sequencer
//   waits on it and keeps every result in order.
// Reset: counters, ring position and running flag clear, base address to 0,
//   prebuffer slots to 8.
// ----------------------------------------------------------------------------
module dma_descriptor_ring_feeder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [drf_pkg::ADDR_W-1:0]    cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [drf_pkg::FIFO_W-1:0]    s_fifo_bytes,
    input  logic                          s_halted,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [drf_pkg::SLOT_W-1:0]    m_slot_index,
    output logic [drf_pkg::ADDR_W-1:0]    m_buf_addr,
    output logic [11:0]                   m_sample_count,
    output logic                          m_flag_ioc,
    output logic                          m_flag_bup,
    output logic [drf_pkg::TAKE_W-1:0]    m_bytes_taken,
    output logic [drf_pkg::SLOT_W-1:0]    m_in_flight_now,
    output logic                          m_is_running,
    output logic                          m_last
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ACK   = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_START = 5'b01000,
        ST_SUM   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [drf_pkg::ADDR_W-1:0] base_reg;
    logic [drf_pkg::PREB_W-1:0] prebuf_reg;

    logic [drf_pkg::SLOT_W-1:0] queued_reg, queued_next;
    logic [drf_pkg::SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [drf_pkg::SLOT_W-1:0] last_slot_reg, last_slot_next;
    logic                       running_reg, running_next;
    logic [drf_pkg::FIFO_W-1:0] rem_reg, rem_next;
    logic                       halted_reg, halted_next;

    logic                       out_valid_reg, out_valid_next;
    drf_pkg::kind_t             kind_reg, kind_next;
    logic [drf_pkg::SLOT_W-1:0] slot_out_reg, slot_out_next;
    logic [drf_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [drf_pkg::TAKE_W-1:0] taken_reg, taken_next;
    logic [drf_pkg::SLOT_W-1:0] ifl_out_reg, ifl_out_next;
    logic                       run_out_reg, run_out_next;

    drf_pkg::slot_calc_t        calc;
    logic                       out_free;
    logic                       emit;
    logic [drf_pkg::PREB_W-1:0] need;
    logic                       start_ok;

    drf_slot_unit u_slot (
        .rem  (rem_reg),
        .slot (next_slot_reg),
        .base (base_reg),
        .calc (calc)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign need     = (prebuf_reg == '0) ? drf_pkg::PREB_W'(1) : prebuf_reg;
    assign start_ok = (queued_reg >= need) ||
                      ((queued_reg != '0) && (rem_reg == '0));

    always_comb begin
        state_next     = state_reg;
        queued_next    = queued_reg;
        next_slot_next = next_slot_reg;
        last_slot_next = last_slot_reg;
        running_next   = running_reg;
        rem_next       = rem_reg;
        halted_next    = halted_reg;
        emit           = 1'b0;
        kind_next      = kind_reg;
        slot_out_next  = slot_out_reg;
        addr_next      = addr_reg;
        taken_next     = taken_reg;
        ifl_out_next   = ifl_out_reg;
        run_out_next   = run_out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rem_next    = s_fifo_bytes;
                    halted_next = s_halted;
                    if (s_op == drf_pkg::OP_FLUSH) begin
                        queued_next    = '0;
                        next_slot_next = '0;
                        last_slot_next = '0;
                        running_next   = 1'b0;
                        state_next     = ST_SUM;
                    end else if (s_op == drf_pkg::OP_KICK || s_op == drf_pkg::OP_IRQ) begin
                        if (s_op == drf_pkg::OP_IRQ && queued_reg != '0) begin
                            queued_next = queued_reg - drf_pkg::SLOT_W'(1);
                        end
                        state_next = ST_ACK;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_ACK: begin
                if (running_reg && halted_reg) begin
                    if (out_free) begin
                        queued_next    = '0;
                        running_next   = 1'b0;
                        emit           = 1'b1;
                        kind_next      = drf_pkg::KIND_HALT_ACK;
                        slot_out_next  = last_slot_reg;
                        addr_next      = '0;
                        taken_next     = '0;
                        ifl_out_next   = '0;
                        run_out_next   = 1'b0;
                        state_next     = ST_FILL;
                    end
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (queued_reg < drf_pkg::MAX_IN_FLIGHT && rem_reg != '0) begin
                    if (out_free) begin
                        rem_next       = calc.rem_next;
                        last_slot_next = next_slot_reg;
                        queued_next    = queued_reg + drf_pkg::SLOT_W'(1);
                        next_slot_next = next_slot_reg + drf_pkg::SLOT_W'(1);
                        emit           = 1'b1;
                        kind_next      = drf_pkg::KIND_SLOT;
                        slot_out_next  = next_slot_reg;
                        addr_next      = calc.addr;
                        taken_next     = calc.take;
                        ifl_out_next   = queued_reg + drf_pkg::SLOT_W'(1);
                        run_out_next   = running_reg;
                    end
                end else begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (!running_reg && start_ok) begin
                    if (out_free) begin
                        running_next  = 1'b1;
                        emit          = 1'b1;
                        kind_next     = drf_pkg::KIND_START;
                        slot_out_next = last_slot_reg;
                        addr_next     = '0;
                        taken_next    = '0;
                        ifl_out_next  = queued_reg;
                        run_out_next  = 1'b1;
                        state_next    = ST_SUM;
                    end
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    emit          = 1'b1;
                    kind_next     = drf_pkg::KIND_SUMMARY;
                    slot_out_next = last_slot_reg;
                    addr_next     = '0;
                    taken_next    = '0;
                    ifl_out_next  = queued_reg;
                    run_out_next  = running_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            queued_reg    <= '0;
            next_slot_reg <= '0;
            last_slot_reg <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            prebuf_reg    <= drf_pkg::PREBUF_RESET;
        end else begin
            state_reg     <= state_next;
            queued_reg    <= queued_next;
            next_slot_reg <= next_slot_next;
            last_slot_reg <= last_slot_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    drf_pkg::CFG_BASE:   base_reg   <= cfg_wdata;
                    drf_pkg::CFG_PREBUF: prebuf_reg <= cfg_wdata[drf_pkg::PREB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        halted_reg   <= halted_next;
        kind_reg     <= kind_next;
        slot_out_reg <= slot_out_next;
        addr_reg     <= addr_next;
        taken_reg    <= taken_next;
        ifl_out_reg  <= ifl_out_next;
        run_out_reg  <= run_out_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = kind_reg;
    assign m_slot_index    = slot_out_reg;
    assign m_buf_addr      = addr_reg;
    assign m_sample_count  = taken_reg[drf_pkg::TAKE_W-1:1];
    assign m_flag_ioc      = (kind_reg == drf_pkg::KIND_SLOT);
    assign m_flag_bup      = (kind_reg == drf_pkg::KIND_SLOT);
    assign m_bytes_taken   = taken_reg;
    assign m_in_flight_now = ifl_out_reg;
    assign m_is_running    = run_out_reg;
    assign m_last          = (kind_reg == drf_pkg::KIND_SUMMARY);

    // busy for the whole event once it is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("event accepted while previous event in progress");

    // a descriptor always removes bytes from the FIFO
    a_slot_takes_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == drf_pkg::KIND_SLOT) |-> (m_bytes_taken != '0))
        else $error("slot programmed with no bytes");

    // an engine start result reports the engine running
    a_start_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == drf_pkg::KIND_START) |-> m_is_running)
        else $error("start result without running flag");

    // a halt acknowledge leaves nothing in flight and the engine stopped
    a_ack_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == drf_pkg::KIND_HALT_ACK) |->
            (m_in_flight_now == '0 && !m_is_running))
        else $error("halt acknowledge without resync");

    // the sequencer only returns idle right after presenting the summary
    a_idle_after_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && state_next == ST_IDLE) |=>
            (m_valid && m_kind == drf_pkg::KIND_SUMMARY))
        else $error("event ended without summary");

endmodule
